[sv/boi_pkg.sv]
`timescale 1ns / 1ps
package boi_pkg;

   localparam int MUL_W = 64;
   localparam int PROD_W = 2 * MUL_W;
   localparam int DIV_N = 128;
   localparam int DIV_D = 64;
   localparam int CORD_W = 34;
   localparam int ATAN_LEN = 24;
   localparam int ATAN_IW = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [29:0] ATAN_TAB [ATAN_LEN] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
      30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
   };

   localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [CORD_W-1:0] ANG_QUARTER = 34'sd1073741824;
   localparam logic signed [CORD_W-1:0] ANG_HALF = 34'sd2147483648;
   localparam logic [29:0] UNITS_PER_RAD = 30'd683565276;
   localparam logic [19:0] NM_PER_MM = 20'd1000000;

   localparam logic [CSR_IDX_W-1:0] CSR_WHEELBASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_FLOOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEER_FLOOR = 2'd2;

   localparam logic [15:0] WHEELBASE_RESET = 16'd2500;
   localparam logic [9:0] SPEED_FLOOR_RESET = 10'd1;
   localparam logic [14:0] STEER_FLOOR_RESET = 15'd18;

   typedef struct packed {
      logic busy;
      logic done;
   } boi_unit_status_type;

endpackage

[sv/boi_req_if.sv]
`timescale 1ns / 1ps
interface boi_req_if;
   logic valid;
   logic ready;
   logic [31:0] timestamp_us;
   logic signed [15:0] speed_mm_s;
   logic signed [15:0] steer_angle;

   modport source (output valid, timestamp_us, speed_mm_s, steer_angle, input ready);
   modport sink (input valid, timestamp_us, speed_mm_s, steer_angle, output ready);
endinterface

[sv/boi_rsp_if.sv]
`timescale 1ns / 1ps
interface boi_rsp_if;
   logic valid;
   logic ready;
   logic signed [47:0] pose_x_nm;
   logic signed [47:0] pose_y_nm;
   logic [15:0] heading_angle;
   logic moved;
   logic turned;
   logic signed [47:0] odometer_nm;
   logic first_reading;

   modport source (output valid, pose_x_nm, pose_y_nm, heading_angle, moved, turned,
                   odometer_nm, first_reading, input ready);
   modport sink (input valid, pose_x_nm, pose_y_nm, heading_angle, moved, turned,
                 odometer_nm, first_reading, output ready);
endinterface

[sv/boi_serial_mul.sv]
`timescale 1ns / 1ps
module boi_serial_mul (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [boi_pkg::MUL_W-1:0] a,
   input  logic [boi_pkg::MUL_W-1:0] b,
   output logic [boi_pkg::PROD_W-1:0] prod,
   output boi_pkg::boi_unit_status_type status
);
   import boi_pkg::*;

   localparam int CW = $clog2(MUL_W);

   logic [MUL_W-1:0] a_ff, a_in, hi_ff, hi_in, lo_ff, lo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [MUL_W:0] sum;

   // One multiplier bit per cycle, the product shifting right into the low half.
   assign sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : {(MUL_W + 1){1'b0}});

   always_comb begin
      a_in = a_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in = a;
         hi_in = '0;
         lo_in = b;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in = sum[MUL_W:1];
         lo_in = {sum[0], lo_ff[MUL_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(MUL_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign prod = {hi_ff, lo_ff};
   assign status.busy = busy_ff;
   assign status.done = done_ff;
endmodule

[sv/boi_serial_div.sv]
`timescale 1ns / 1ps
module boi_serial_div (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [boi_pkg::DIV_N-1:0] num,
   input  logic [boi_pkg::DIV_D-1:0] den,
   output logic [boi_pkg::DIV_D-1:0] quot,
   output boi_pkg::boi_unit_status_type status
);
   import boi_pkg::*;

   localparam int CW = $clog2(DIV_N);

   logic [DIV_N-1:0] num_ff, num_in;
   logic [DIV_D-1:0] rem_ff, rem_in, den_ff, den_in, q_ff, q_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [DIV_D:0] trial, diff;
   logic ge;

   // Restoring division, one dividend bit per cycle from the top.
   assign trial = {rem_ff, num_ff[DIV_N-1]};
   assign ge = trial >= {1'b0, den_ff};
   assign diff = trial - {1'b0, den_ff};

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = num;
         rem_in = '0;
         den_in = den;
         q_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_N-2:0], 1'b0};
         rem_in = ge ? diff[DIV_D-1:0] : trial[DIV_D-1:0];
         q_in = {q_ff[DIV_D-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DIV_N - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff <= q_in;
   end

   assign quot = q_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;
endmodule

[sv/boi_cordic.sv]
`timescale 1ns / 1ps
module boi_cordic #(
   parameter int STEPS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [15:0] angle,
   output logic signed [boi_pkg::CORD_W-1:0] cos_q30,
   output logic signed [boi_pkg::CORD_W-1:0] sin_q30,
   output boi_pkg::boi_unit_status_type status
);
   import boi_pkg::*;

   localparam int IW = $clog2(STEPS);

   logic signed [CORD_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [CORD_W-1:0] z0, xs, ys, at;
   logic flip_ff, flip_in;
   logic [IW-1:0] i_ff, i_in;
   logic busy_ff, busy_in, done_ff, done_in;

   assign z0 = CORD_W'(signed'({angle, 16'b0}));
   assign xs = x_ff >>> i_ff;
   assign ys = y_ff >>> i_ff;
   assign at = signed'({{(CORD_W - 30){1'b0}}, ATAN_TAB[ATAN_IW'(i_ff)]});

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      flip_in = flip_ff;
      i_in = i_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in = CORDIC_GAIN;
         y_in = '0;
         busy_in = 1'b1;
         i_in = '0;
         if (z0 > ANG_QUARTER) begin
            z_in = z0 - ANG_HALF;
            flip_in = 1'b1;
         end else if (z0 < -ANG_QUARTER) begin
            z_in = z0 + ANG_HALF;
            flip_in = 1'b1;
         end else begin
            z_in = z0;
            flip_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (!z_ff[CORD_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         i_in = i_ff + 1'b1;
         if (i_ff == IW'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         i_ff <= i_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      flip_ff <= flip_in;
   end

   assign cos_q30 = flip_ff ? -x_ff : x_ff;
   assign sin_q30 = flip_ff ? -y_ff : y_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;
endmodule

[sv/bicycle_odometry_integrator.sv]
`timescale 1ns / 1ps
// Each accepted beat runs in turn through the bit-serial multiplier, the CORDIC and the
// 128-step restoring divider. No new reading is taken until the last result has been loaded
// into the output register. The first reading after reset skips the arithmetic and goes
// straight to the output register. A result still waiting in the output register holds the
// next finished reading. Reset is synchronous and active high: it clears the pose, the
// odometer, the timing state and the output, and loads the register defaults.
module bicycle_odometry_integrator #(
   parameter int CORDIC_STEPS = 16,
   parameter int POS_BITS = 48
) (
   input  logic clock,
   input  logic reset,
   boi_req_if.sink req_ch,
   boi_rsp_if.source rsp_ch,
   input  logic csr_we,
   input  logic [boi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [boi_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import boi_pkg::*;

   localparam int SW = 66;
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_MUL_D = 4'd1;
   localparam logic [3:0] ST_COR_H = 4'd2;
   localparam logic [3:0] ST_MUL_X = 4'd3;
   localparam logic [3:0] ST_MUL_Y = 4'd4;
   localparam logic [3:0] ST_COR_S = 4'd5;
   localparam logic [3:0] ST_DIV_T = 4'd6;
   localparam logic [3:0] ST_MUL_K = 4'd7;
   localparam logic [3:0] ST_MUL_H = 4'd8;
   localparam logic [3:0] ST_DIV_H = 4'd9;
   localparam logic [3:0] ST_DONE = 4'd10;

   function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] pmax, pmin;
      pmax = signed'((SW'(1) << (POS_BITS - 1)) - SW'(1));
      pmin = -pmax - SW'(1);
      if (v > pmax) return POS_BITS'(pmax);
      if (v < pmin) return POS_BITS'(pmin);
      return POS_BITS'(v);
   endfunction

   logic [3:0] state_ff, state_in;
   logic go_ff, go_in;
   logic [15:0] wb_ff, wb_in;
   logic [9:0] speed_floor_ff, speed_floor_in;
   logic [14:0] steer_floor_ff, steer_floor_in;
   logic started_ff, started_in;
   logic [31:0] last_time_ff, last_time_in, dt_ff, dt_in;
   logic signed [POS_BITS-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, trav_ff, trav_in;
   logic [15:0] heading_ff, heading_in, v_ff, v_in, st_ff, st_in;
   logic [47:0] leg_mag_ff, leg_mag_in;
   logic leg_neg_ff, leg_neg_in;
   logic first_ff, first_in, moved_ff, moved_in, turned_ff, turned_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [47:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_odo_ff, rsp_odo_in;
   logic [15:0] rsp_head_ff, rsp_head_in;
   logic rsp_moved_ff, rsp_moved_in, rsp_turned_ff, rsp_turned_in;
   logic rsp_first_ff, rsp_first_in;

   logic req_acc, rsp_load;
   logic mul_start, div_start, cor_start;
   logic [MUL_W-1:0] mul_a, mul_b;
   logic [PROD_W-1:0] mul_prod;
   logic [DIV_N-1:0] div_num;
   logic [DIV_D-1:0] div_den, div_q;
   logic [15:0] cor_angle;
   logic signed [CORD_W-1:0] cor_c, cor_s, trig;
   boi_unit_status_type mul_st, div_st, cor_st;

   logic [15:0] v_mag, st_mag, wb_eff, delta_h, hstep;
   logic [CORD_W-1:0] trig_mag, sm, cm;
   logic [79:0] rnd;
   logic signed [SW-1:0] r_s, dpos, pos_old, leg_s;
   logic signed [POS_BITS-1:0] pos_new;
   logic sat_t, hneg;
   logic [31:0] tmag;
   logic [35:0] d_prod;
   logic [47:0] hq;

   boi_serial_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .prod(mul_prod), .status(mul_st)
   );

   boi_serial_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(div_den),
      .quot(div_q), .status(div_st)
   );

   boi_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cor_start), .angle(cor_angle),
      .cos_q30(cor_c), .sin_q30(cor_s), .status(cor_st)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_acc = req_ch.valid && req_ch.ready;
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   assign v_mag = v_ff[15] ? (~v_ff + 1'b1) : v_ff;
   assign st_mag = st_ff[15] ? (~st_ff + 1'b1) : st_ff;
   assign wb_eff = (wb_ff == '0) ? 16'd1 : wb_ff;
   assign d_prod = wb_eff * NM_PER_MM;

   // Position step: the travelled length times cos or sin, rounded from Q30 with halves
   // away from zero.
   assign trig = (state_ff == ST_MUL_X) ? cor_c : cor_s;
   assign trig_mag = trig[CORD_W-1] ? unsigned'(-trig) : unsigned'(trig);
   assign rnd = mul_prod[79:0] + (80'd1 << 29);
   assign r_s = signed'(SW'(rnd[79:30]));
   assign dpos = (leg_neg_ff ^ trig[CORD_W-1]) ? -r_s : r_s;
   assign pos_old = (state_ff == ST_MUL_X) ? SW'(pos_x_ff) : SW'(pos_y_ff);
   assign pos_new = sat_pos(pos_old + dpos);
   assign leg_s = leg_neg_ff ? -signed'(SW'(leg_mag_ff)) : signed'(SW'(leg_mag_ff));

   // Steering tangent in Q16, clamped near ninety degrees.
   assign sm = cor_s[CORD_W-1] ? unsigned'(-cor_s) : unsigned'(cor_s);
   assign cm = cor_c[CORD_W-1] ? unsigned'(-cor_c) : unsigned'(cor_c);
   assign sat_t = {15'b0, sm} >= {cm, 15'b0};
   assign tmag = sat_t ? 32'h8000_0000 : div_q[31:0];
   assign hneg = (cor_s[CORD_W-1] ^ cor_c[CORD_W-1]) ^ leg_neg_ff;
   assign hq = div_q[47:0] + 48'h0000_8000_0000;
   assign delta_h = hq[47:32];
   assign hstep = hneg ? (~delta_h + 1'b1) : delta_h;

   assign mul_start = go_ff && (state_ff inside {ST_MUL_D, ST_MUL_X, ST_MUL_Y, ST_MUL_K,
                                                  ST_MUL_H});
   assign div_start = go_ff && (state_ff inside {ST_DIV_T, ST_DIV_H});
   assign cor_start = go_ff && (state_ff inside {ST_COR_H, ST_COR_S});
   assign cor_angle = (state_ff == ST_COR_H) ? heading_ff : st_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      div_num = '0;
      div_den = '0;
      case (state_ff)
         ST_MUL_D: begin
            mul_a = MUL_W'(v_mag);
            mul_b = MUL_W'(dt_ff);
         end
         ST_MUL_X, ST_MUL_Y: begin
            mul_a = MUL_W'(leg_mag_ff);
            mul_b = MUL_W'(trig_mag);
         end
         ST_MUL_K: begin
            mul_a = MUL_W'(tmag);
            mul_b = MUL_W'(UNITS_PER_RAD);
         end
         ST_MUL_H: begin
            mul_a = MUL_W'(leg_mag_ff);
            mul_b = mul_prod[MUL_W-1:0];
         end
         ST_DIV_T: begin
            div_num = DIV_N'({sm, 16'b0});
            div_den = DIV_D'(cm);
         end
         ST_DIV_H: begin
            div_num = mul_prod;
            div_den = DIV_D'(d_prod);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      go_in = 1'b0;
      wb_in = wb_ff;
      speed_floor_in = speed_floor_ff;
      steer_floor_in = steer_floor_ff;
      started_in = started_ff;
      last_time_in = last_time_ff;
      dt_in = dt_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      trav_in = trav_ff;
      heading_in = heading_ff;
      v_in = v_ff;
      st_in = st_ff;
      leg_mag_in = leg_mag_ff;
      leg_neg_in = leg_neg_ff;
      first_in = first_ff;
      moved_in = moved_ff;
      turned_in = turned_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_WHEELBASE: wb_in = csr_wdata;
            CSR_SPEED_FLOOR: speed_floor_in = csr_wdata[9:0];
            CSR_STEER_FLOOR: steer_floor_in = csr_wdata[14:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               v_in = req_ch.speed_mm_s;
               st_in = req_ch.steer_angle;
               last_time_in = req_ch.timestamp_us;
               dt_in = req_ch.timestamp_us - last_time_ff;
               moved_in = 1'b0;
               turned_in = 1'b0;
               if (!started_ff) begin
                  started_in = 1'b1;
                  pos_x_in = '0;
                  pos_y_in = '0;
                  heading_in = '0;
                  first_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  first_in = 1'b0;
                  state_in = ST_MUL_D;
                  go_in = 1'b1;
               end
            end
         end
         ST_MUL_D: begin
            if (mul_st.done) begin
               leg_mag_in = mul_prod[47:0];
               leg_neg_in = v_ff[15] && (dt_ff != '0);
               state_in = ST_COR_H;
               go_in = 1'b1;
            end
         end
         ST_COR_H: begin
            if (cor_st.done) begin
               state_in = ST_MUL_X;
               go_in = 1'b1;
            end
         end
         ST_MUL_X: begin
            if (mul_st.done) begin
               pos_x_in = pos_new;
               state_in = ST_MUL_Y;
               go_in = 1'b1;
            end
         end
         ST_MUL_Y: begin
            if (mul_st.done) begin
               pos_y_in = pos_new;
               state_in = ST_COR_S;
               go_in = 1'b1;
            end
         end
         ST_COR_S: begin
            if (cor_st.done) begin
               state_in = ST_DIV_T;
               go_in = 1'b1;
            end
         end
         ST_DIV_T: begin
            if (div_st.done) begin
               state_in = ST_MUL_K;
               go_in = 1'b1;
            end
         end
         ST_MUL_K: begin
            if (mul_st.done) begin
               state_in = ST_MUL_H;
               go_in = 1'b1;
            end
         end
         ST_MUL_H: begin
            if (mul_st.done) begin
               state_in = ST_DIV_H;
               go_in = 1'b1;
            end
         end
         ST_DIV_H: begin
            if (div_st.done) begin
               heading_in = heading_ff + hstep;
               if (v_mag > {6'b0, speed_floor_ff}) begin
                  moved_in = 1'b1;
                  turned_in = st_mag > {1'b0, steer_floor_ff};
                  trav_in = sat_pos(SW'(trav_ff) + leg_s);
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_x_in = rsp_x_ff;
      rsp_y_in = rsp_y_ff;
      rsp_odo_in = rsp_odo_ff;
      rsp_head_in = rsp_head_ff;
      rsp_moved_in = rsp_moved_ff;
      rsp_turned_in = rsp_turned_ff;
      rsp_first_in = rsp_first_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_x_in = 48'(pos_x_ff);
         rsp_y_in = 48'(pos_y_ff);
         rsp_odo_in = 48'(trav_ff);
         rsp_head_in = heading_ff;
         rsp_moved_in = moved_ff;
         rsp_turned_in = turned_ff;
         rsp_first_in = first_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         go_ff <= 1'b0;
         wb_ff <= WHEELBASE_RESET;
         speed_floor_ff <= SPEED_FLOOR_RESET;
         steer_floor_ff <= STEER_FLOOR_RESET;
         started_ff <= 1'b0;
         last_time_ff <= '0;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         trav_ff <= '0;
         heading_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff <= go_in;
         wb_ff <= wb_in;
         speed_floor_ff <= speed_floor_in;
         steer_floor_ff <= steer_floor_in;
         started_ff <= started_in;
         last_time_ff <= last_time_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         trav_ff <= trav_in;
         heading_ff <= heading_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff <= dt_in;
      v_ff <= v_in;
      st_ff <= st_in;
      leg_mag_ff <= leg_mag_in;
      leg_neg_ff <= leg_neg_in;
      first_ff <= first_in;
      moved_ff <= moved_in;
      turned_ff <= turned_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_odo_ff <= rsp_odo_in;
      rsp_head_ff <= rsp_head_in;
      rsp_moved_ff <= rsp_moved_in;
      rsp_turned_ff <= rsp_turned_in;
      rsp_first_ff <= rsp_first_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.pose_x_nm = rsp_x_ff;
   assign rsp_ch.pose_y_nm = rsp_y_ff;
   assign rsp_ch.heading_angle = rsp_head_ff;
   assign rsp_ch.moved = rsp_moved_ff;
   assign rsp_ch.turned = rsp_turned_ff;
   assign rsp_ch.odometer_nm = rsp_odo_ff;
   assign rsp_ch.first_reading = rsp_first_ff;

   a_one_unit_busy: assert property (@(posedge clock) disable iff (reset)
      $countones({mul_st.busy, div_st.busy, cor_st.busy}) <= 1)
      else $error("more than one arithmetic unit busy");

   a_mul_done_in_mul_state: assert property (@(posedge clock) disable iff (reset)
      mul_st.done |-> (state_ff == ST_MUL_D || state_ff == ST_MUL_X ||
                       state_ff == ST_MUL_Y || state_ff == ST_MUL_K || state_ff == ST_MUL_H))
      else $error("multiplier finished outside a multiply step");

   a_first_clears_pose: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && first_ff) |->
         (pos_x_ff == '0 && pos_y_ff == '0 && heading_ff == '0))
      else $error("first reading did not clear the pose");

   a_rsp_first_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.first_reading) |-> (!rsp_ch.moved && !rsp_ch.turned))
      else $error("first reading beat reports motion");
endmodule

[test/tb.sv]
`timescale 1ns / 1ps
module tb;
   import boi_pkg::*;

   localparam int CORDIC_STEPS = 16;
   localparam longint POS_MAX = 64'sd140737488355327;
   localparam longint POS_MIN = -POS_MAX - 1;
   localparam int SETTLE = 800;
   localparam longint LIMIT = 4000000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic [31:0] ts;
      logic signed [15:0] speed;
      logic signed [15:0] steer;
   } reading_type;

   typedef struct {
      logic signed [47:0] x;
      logic signed [47:0] y;
      logic [15:0] hd;
      logic moved;
      logic turned;
      logic signed [47:0] odo;
      logic first;
   } pose_type;

   function automatic logic [63:0] magnitude(input longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   // Rotation-mode CORDIC on a 32-bit binary angle, folded to +-90 degrees.
   function automatic void rotate(input logic [31:0] ang, output longint c, output longint s);
      longint z, x, y, nx;
      bit flip;
      z = longint'({32'd0, ang});
      if (z >= 64'sd2147483648) z -= 64'sd4294967296;
      x = 652032874;
      y = 0;
      flip = 0;
      if (z > 64'sd1073741824) begin
         z -= 64'sd2147483648;
         flip = 1;
      end else if (z < -64'sd1073741824) begin
         z += 64'sd2147483648;
         flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= longint'(ATAN_TAB[i]);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += longint'(ATAN_TAB[i]);
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint scale_q30(input longint a, input longint b);
      logic [127:0] p;
      logic [63:0] r;
      p = 128'(magnitude(a)) * 128'(magnitude(b));
      r = 64'((p + (128'd1 << 29)) >> 30);
      return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint clamp_add(input longint a, input longint b);
      longint t;
      t = a + b;
      if (t > POS_MAX) return POS_MAX;
      if (t < POS_MIN) return POS_MIN;
      return t;
   endfunction

   class pose_scoreboard_type;
      logic [15:0] wheelbase = WHEELBASE_RESET;
      logic [9:0] speed_floor = SPEED_FLOOR_RESET;
      logic [14:0] steer_floor = STEER_FLOOR_RESET;
      bit started;
      logic [31:0] last_ts;
      longint px, py, odo;
      logic [15:0] heading;
      pose_type pending[$];
      int errors;

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_WHEELBASE) wheelbase = val;
         else if (idx == CSR_SPEED_FLOOR) speed_floor = val[9:0];
         else if (idx == CSR_STEER_FLOOR) steer_floor = val[14:0];
      endfunction

      function logic [15:0] turn_step(longint leg, logic [15:0] steer);
         longint c, s;
         logic [63:0] sm, cm, tmag, k, q, d, dlt;
         logic [127:0] prod;
         rotate({steer, 16'd0}, c, s);
         sm = magnitude(s);
         cm = magnitude(c);
         if (sm >= (cm << 15)) tmag = 64'h8000_0000;
         else tmag = (sm << 16) / cm;
         k = tmag * 64'd683565276;
         prod = 128'(magnitude(leg)) * 128'(k);
         d = 64'(wheelbase == 0 ? 16'd1 : wheelbase) * 64'd1000000;
         q = 64'(prod / 128'(d));
         dlt = ((q + 64'h8000_0000) >> 32) & 64'hFFFF;
         if (((s < 0) != (c < 0)) != (leg < 0)) dlt = (64'd0 - dlt) & 64'hFFFF;
         return dlt[15:0];
      endfunction

      function void note(reading_type r);
         pose_type e;
         longint leg, c, s, v, st;
         logic [31:0] dt;
         v = longint'(r.speed);
         st = longint'(r.steer);
         e.moved = 0;
         e.turned = 0;
         e.first = 0;
         if (!started) begin
            started = 1;
            last_ts = r.ts;
            px = 0;
            py = 0;
            heading = 0;
            e.first = 1;
         end else begin
            dt = r.ts - last_ts;
            last_ts = r.ts;
            leg = v * longint'({32'd0, dt});
            rotate({heading, 16'd0}, c, s);
            px = clamp_add(px, scale_q30(leg, c));
            py = clamp_add(py, scale_q30(leg, s));
            heading = heading + turn_step(leg, r.steer);
            if (magnitude(v) > 64'(speed_floor)) begin
               e.moved = 1;
               e.turned = magnitude(st) > 64'(steer_floor);
               odo = clamp_add(odo, leg);
            end
         end
         e.x = px[47:0];
         e.y = py[47:0];
         e.hd = heading;
         e.odo = odo[47:0];
         pending.push_back(e);
      endfunction

      function void flag(string field, logic [47:0] want, logic [47:0] got);
         errors++;
         if (errors <= 10)
            $display("%0t %s: expected %h, got %h", $time, field, want, got);
      endfunction

      function void check(pose_type a);
         pose_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("%0t result beat with nothing expected", $time);
            return;
         end
         e = pending.pop_front();
         if (a.x !== e.x) flag("pose_x_nm", e.x, a.x);
         if (a.y !== e.y) flag("pose_y_nm", e.y, a.y);
         if (a.hd !== e.hd) flag("heading_angle", 48'(e.hd), 48'(a.hd));
         if (a.moved !== e.moved) flag("moved", 48'(e.moved), 48'(a.moved));
         if (a.turned !== e.turned) flag("turned", 48'(e.turned), 48'(a.turned));
         if (a.odo !== e.odo) flag("odometer_nm", e.odo, a.odo);
         if (a.first !== e.first) flag("first_reading", 48'(e.first), 48'(a.first));
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_WHEELBASE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int send_idle = 15;
   int recv_idle = 70;
   longint cycles = 0;
   logic [31:0] now_ts;
   pose_scoreboard_type sb;

   boi_req_if req_ch();
   boi_rsp_if rsp_ch();

   bicycle_odometry_integrator i_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   initial begin
      req_ch.valid = 0;
      req_ch.timestamp_us = '0;
      req_ch.speed_mm_s = '0;
      req_ch.steer_angle = '0;
      rsp_ch.ready = 0;
   end

   always @(negedge clock) begin
      rsp_ch.ready = ($urandom_range(0, 99) >= recv_idle);
   end

   always @(posedge clock) begin
      pose_type a;
      cycles++;
      if (cycles > LIMIT) begin
         $display("bicycle_odometry_integrator: mismatch");
         $finish;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         a.x = rsp_ch.pose_x_nm;
         a.y = rsp_ch.pose_y_nm;
         a.hd = rsp_ch.heading_angle;
         a.moved = rsp_ch.moved;
         a.turned = rsp_ch.turned;
         a.odo = rsp_ch.odometer_nm;
         a.first = rsp_ch.first_reading;
         sb.check(a);
      end
   end

   task automatic send(input logic [31:0] ts, input logic [15:0] spd, input logic [15:0] str);
      reading_type r;
      while ($urandom_range(0, 99) < send_idle) @(negedge clock);
      r.ts = ts;
      r.speed = spd;
      r.steer = str;
      req_ch.valid = 1;
      req_ch.timestamp_us = ts;
      req_ch.speed_mm_s = spd;
      req_ch.steer_angle = str;
      do @(posedge clock); while (!req_ch.ready);
      sb.note(r);
      now_ts = ts;
      @(negedge clock);
      req_ch.valid = 0;
   endtask

   task automatic after(input logic [31:0] dt, input logic [15:0] spd, input logic [15:0] str);
      send(now_ts + dt, spd, str);
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = val;
      sb.set_reg(idx, val);
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic random_readings(input int n);
      logic [31:0] dt;
      logic [15:0] spd, str;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0: dt = $urandom;
            1: dt = $urandom_range(0, 3);
            default: dt = $urandom_range(1000, 200000);
         endcase
         case ($urandom_range(0, 9))
            0: spd = 16'($urandom_range(0, 1002)) - 16'd501;
            1, 2: spd = 16'($urandom);
            default: spd = 16'($urandom_range(0, 6000)) - 16'd3000;
         endcase
         if ($urandom_range(0, 9) < 7) str = 16'($urandom_range(0, 32768)) - 16'd16384;
         else str = 16'($urandom);
         after(dt, spd, str);
      end
   endtask

   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // The first beat only sets the time; the next one crosses the timestamp wrap.
      send(32'hFFFF_FFF0, 16'sd500, 16'sd300);
      after(32'd100, 16'sd1000, 16'sd0);
      after(32'd50000, 16'sd32767, 16'sd16384);
      after(32'd50000, 16'sh8000, -16'sd16384);
      after(32'd20000, 16'sd1200, 16'sd16383);
      after(32'd20000, 16'sd1200, -16'sd16385);
      after(32'd20000, 16'sd1200, 16'sh7FFF);
      after(32'd20000, -16'sd1200, 16'sh8000);
      after(32'd20000, 16'sd1, 16'sd4000);
      after(32'd20000, -16'sd2, 16'sd18);
      after(32'd20000, 16'sd2, -16'sd19);
      after(32'd0, 16'sd3000, 16'sd500);
      after(32'd30000, 16'sd0, 16'sd0);
      after(32'hFFFF_FFFF, 16'sd32767, 16'sd100);
      after(32'hFFFF_FFFF, 16'sd32767, 16'sd100);
      after(32'hFFFF_FFFF, 16'sd32767, -16'sd100);
      after(32'hFFFF_FFFF, 16'sh8000, 16'sd8192);
      after(32'hFFFF_FFFF, 16'sh8000, -16'sd8192);
      after(32'hFFFF_FFFF, 16'sh8000, 16'sd0);
      after(32'd1, 16'sd700, 16'sd2000);
      random_readings(200);
      drain();

      write_reg(CSR_WHEELBASE, 16'd1);
      write_reg(CSR_SPEED_FLOOR, 16'd1000);
      write_reg(CSR_STEER_FLOOR, 16'd16384);
      write_reg(CSR_SPARE, 16'hFFFF);
      random_readings(150);
      drain();

      send_idle = 70;
      recv_idle = 15;
      write_reg(CSR_WHEELBASE, 16'd65535);
      write_reg(CSR_SPEED_FLOOR, 16'd0);
      write_reg(CSR_STEER_FLOOR, 16'd0);
      random_readings(200);
      drain();

      write_reg(CSR_WHEELBASE, 16'd0);
      write_reg(CSR_SPEED_FLOOR, 16'hFFFF);
      write_reg(CSR_STEER_FLOOR, 16'hFFFF);
      random_readings(80);
      drain();

      send_idle = 0;
      recv_idle = 0;
      write_reg(CSR_WHEELBASE, 16'd1800);
      write_reg(CSR_SPEED_FLOOR, 16'd250);
      write_reg(CSR_STEER_FLOOR, 16'd600);
      random_readings(250);
      drain();

      if (sb.errors == 0) begin
         $display("bicycle_odometry_integrator: match");
      end else begin
         $display("bicycle_odometry_integrator: mismatch");
      end
      $finish;
   end
endmodule
